@@ src/hhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat health supervisor package
// Shared widths, codes, reset values, the result structure and the structures
// that travel between the top level and the row of channel cells.
// ----------------------------------------------------------------------------
package hhs_pkg;

   localparam int CHANNELS  = 5;
   localparam int MASK_W    = 5;
   localparam int TIME_W    = 32;
   localparam int LIMIT_W   = 16;
   localparam int CH_W      = 3;
   localparam int ACT_W     = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BEAT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CHECK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_INPUT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_RUNTIME = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_STORAGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_AUDIO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_MONITOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STARTUP_GRACE = 3'd5;

   localparam logic [LIMIT_W-1:0] GRACE_RESET = 16'd15000;

   localparam logic [MASK_W-1:0] ALL_MASK = MASK_W'((1 << CHANNELS) - 1);

   // Reset value of the timeout limit of one channel.
   function automatic logic [LIMIT_W-1:0] limit_reset(input logic [CSR_IDX_W-1:0] idx);
      logic [LIMIT_W-1:0] val;
      case (idx)
         REG_LIMIT_INPUT:   val = 16'd1500;
         REG_LIMIT_RUNTIME: val = 16'd1500;
         REG_LIMIT_STORAGE: val = 16'd10000;
         REG_LIMIT_AUDIO:   val = 16'd5000;
         REG_LIMIT_MONITOR: val = 16'd2000;
         default:           val = '0;
      endcase
      return val;
   endfunction

   // Check token that ripples down the cell row collecting mask bits.
   typedef struct packed {
      logic              valid;
      logic [MASK_W-1:0] healthy;
      logic [MASK_W-1:0] timeout;
   } hhs_token_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic                 beat;
      logic [CH_W-1:0]      beat_ch;
      logic [TIME_W-1:0]    time_now;
      logic                 to_en;
      logic                 csr_we;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [LIMIT_W-1:0]   csr_data;
   } hhs_cell_ctl_type;

   // One result.
   typedef struct packed {
      logic [MASK_W-1:0] seen_mask;
      logic [MASK_W-1:0] alive_mask;
      logic [MASK_W-1:0] expired_mask;
      logic              startup_done;
      logic              watchdog_armed;
      logic              feed;
      logic              fault;
      logic [CH_W-1:0]   fault_channel;
   } hhs_rsp_type;

endpackage
`default_nettype wire

@@ src/hhs_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat health supervisor channels
// Valid/ready interfaces for the request, result and register write channels.
// ----------------------------------------------------------------------------
interface hhs_req_if import hhs_pkg::*;;
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [CH_W-1:0]  channel;

   modport source (output valid, output action, output channel, input ready);
   modport sink (input valid, input action, input channel, output ready);
endinterface

interface hhs_rsp_if import hhs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] seen_mask;
   logic [MASK_W-1:0] alive_mask;
   logic [MASK_W-1:0] expired_mask;
   logic              startup_done;
   logic              watchdog_armed;
   logic              feed;
   logic              fault;
   logic [CH_W-1:0]   fault_channel;

   modport source (output valid, output seen_mask, output alive_mask,
                   output expired_mask, output startup_done, output watchdog_armed,
                   output feed, output fault, output fault_channel, input ready);
   modport sink (input valid, input seen_mask, input alive_mask,
                 input expired_mask, input startup_done, input watchdog_armed,
                 input feed, input fault, input fault_channel, output ready);
endinterface

interface hhs_csr_if import hhs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIMIT_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/heartbeat_health_supervisor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat health supervisor
// Watches five heartbeat channels and decides when to feed a watchdog.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_if (action, channel). A tick advances the
// 32-bit time, a beat stamps its channel with the current time, a check
// classifies every channel. Each request yields exactly one result on rsp_if
// holding the masks and flags after the request; feed is high only on a check
// that refreshes the watchdog. Limits and the startup grace are written
// through csr_if, which is always ready; the user makes writes only
// while the block is idle, which the block does not enforce. A tick, a beat,
// an unused action or a check made after a fault is finished on acceptance,
// and the next request can enter as its result moves on, so one such
// request can pass every cycle while the receiver takes every result. A
// live check walks a token down the row of channel cells, one cell per cycle;
// the flags settle at the end of the row, and only then can the next enter.
// The result register decouples the sides: a new request is taken while one
// result waits, but a second finished result holds off further requests
// until the receiver takes the first. Reset clears time, seen bits, flags and
// the fault latch and restores the default limits.
// ----------------------------------------------------------------------------
module heartbeat_health_supervisor import hhs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   hhs_req_if.sink   req_if,
   hhs_rsp_if.source rsp_if,
   hhs_csr_if.sink   csr_if
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_CHECK = 1'b1;

   // Lowest timed-out channel; with no lower bit set it falls back to the last channel.
   function automatic logic [CH_W-1:0] lowest_set(input logic [MASK_W-1:0] t);
      logic [CH_W-1:0] c;
      c = CH_W'(MASK_W - 1);
      for (int i = MASK_W - 2; i >= 0; i--) begin
         if (t[i]) begin
            c = CH_W'(i);
         end
      end
      return c;
   endfunction

   logic               state_ff, state_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [LIMIT_W-1:0] grace_ff;
   logic [MASK_W-1:0]  healthy_ff, healthy_in;
   logic [MASK_W-1:0]  timeout_ff, timeout_in;
   logic               startup_ff, startup_in;
   logic               armed_ff, armed_in;
   logic               fault_ff, fault_in;
   logic [CH_W-1:0]    fault_ch_ff, fault_ch_in;
   logic               hold_ff, hold_in;
   logic               feed_ff, feed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   hhs_rsp_type        rsp_data_ff;

   logic               move;
   logic               req_acc;
   logic               armed_new;
   hhs_cell_ctl_type   ctl;
   hhs_token_type      inject;
   hhs_token_type      tok_chain [CHANNELS];
   logic [CHANNELS-1:0] seen_vec;
   logic [MASK_W-1:0]  seen_mask;
   hhs_token_type      tok_last;

   // A finished result moves into the result register when it is free.
   assign move    = hold_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_acc = req_if.valid && req_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE) && (!hold_ff || move);
   assign csr_if.ready = 1'b1;

   assign seen_mask = MASK_W'(seen_vec);
   assign tok_last  = tok_chain[CHANNELS-1];

   always_comb begin
      ctl.beat     = req_acc && (req_if.action == ACT_BEAT);
      ctl.beat_ch  = req_if.channel;
      ctl.time_now = time_ff;
      ctl.to_en    = startup_ff || (time_ff > TIME_W'(grace_ff));
      ctl.csr_we   = csr_if.valid;
      ctl.csr_idx  = csr_if.index;
      ctl.csr_data = csr_if.data;

      inject.valid   = req_acc && (req_if.action == ACT_CHECK) && !fault_ff;
      inject.healthy = '0;
      inject.timeout = '0;
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
      hhs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (CH_W'(g)),
         .ctl     (ctl),
         .tok_up  ((g == 0) ? inject : tok_chain[(g == 0) ? 0 : g - 1]),
         .tok_out (tok_chain[g]),
         .seen    (seen_vec[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      healthy_in   = healthy_ff;
      timeout_in   = timeout_ff;
      startup_in   = startup_ff;
      armed_in     = armed_ff;
      fault_in     = fault_ff;
      fault_ch_in  = fault_ch_ff;
      feed_in      = feed_ff;
      hold_in      = hold_ff && !move;
      rsp_valid_in = rsp_valid_ff;
      armed_new    = armed_ff || (tok_last.healthy == ALL_MASK);

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               feed_in = 1'b0;
               if (req_if.action == ACT_CHECK && !fault_ff) begin
                  state_in = ST_CHECK;
               end else begin
                  hold_in = 1'b1;
                  if (req_if.action == ACT_TICK) begin
                     time_in = time_ff + TIME_W'(1);
                  end
               end
            end
         end
         ST_CHECK: begin
            if (tok_last.valid) begin
               healthy_in = tok_last.healthy;
               timeout_in = tok_last.timeout;
               if (tok_last.healthy == ALL_MASK) begin
                  startup_in = 1'b1;
                  armed_in   = 1'b1;
               end
               if (armed_new && (tok_last.timeout != '0)) begin
                  fault_in    = 1'b1;
                  fault_ch_in = lowest_set(tok_last.timeout);
                  feed_in     = 1'b0;
               end else begin
                  feed_in = armed_new;
               end
               hold_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         grace_ff     <= GRACE_RESET;
         healthy_ff   <= '0;
         timeout_ff   <= '0;
         startup_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         fault_ch_ff  <= '0;
         hold_ff      <= 1'b0;
         feed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         healthy_ff   <= healthy_in;
         timeout_ff   <= timeout_in;
         startup_ff   <= startup_in;
         armed_ff     <= armed_in;
         fault_ff     <= fault_in;
         fault_ch_ff  <= fault_ch_in;
         hold_ff      <= hold_in;
         feed_ff      <= feed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && (csr_if.index == REG_STARTUP_GRACE)) begin
            grace_ff <= csr_if.data;
         end
      end
   end

   // The result register samples the state left by the finished request.
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff.seen_mask      <= seen_mask;
         rsp_data_ff.alive_mask     <= healthy_ff;
         rsp_data_ff.expired_mask   <= timeout_ff;
         rsp_data_ff.startup_done   <= startup_ff;
         rsp_data_ff.watchdog_armed <= armed_ff;
         rsp_data_ff.feed           <= feed_ff;
         rsp_data_ff.fault          <= fault_ff;
         rsp_data_ff.fault_channel  <= fault_ch_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.seen_mask      = rsp_data_ff.seen_mask;
   assign rsp_if.alive_mask     = rsp_data_ff.alive_mask;
   assign rsp_if.expired_mask   = rsp_data_ff.expired_mask;
   assign rsp_if.startup_done   = rsp_data_ff.startup_done;
   assign rsp_if.watchdog_armed = rsp_data_ff.watchdog_armed;
   assign rsp_if.feed           = rsp_data_ff.feed;
   assign rsp_if.fault          = rsp_data_ff.fault;
   assign rsp_if.fault_channel  = rsp_data_ff.fault_channel;

   // Once latched, a fault is never released short of reset.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault latch released");

   // A channel is never both healthy and timed out.
   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      (healthy_ff & timeout_ff) == '0)
      else $error("healthy and timeout masks overlap");

   // The check token leaves the row only while a check is running.
   a_token_in_check: assert property (@(posedge clock) disable iff (reset)
      tok_last.valid |-> state_ff == ST_CHECK)
      else $error("check token outside a check");

   // A fed watchdog is armed and free of faults.
   a_feed_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.feed) |-> (rsp_data_ff.watchdog_armed
                                             && !rsp_data_ff.fault))
      else $error("feed without arming or with a fault");

endmodule
`default_nettype wire

@@ src/hhs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heartbeat health supervisor channel cell
// Holds one channel's last beat time, seen bit and limit, and adds its own
// healthy and timeout bits to the check token on its way down the row.
// ----------------------------------------------------------------------------
module hhs_cell import hhs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CH_W-1:0]  cell_id,
   input  wire hhs_cell_ctl_type ctl,
   input  wire hhs_token_type    tok_up,
   output hhs_token_type         tok_out,
   output logic                  seen
);

   logic [TIME_W-1:0]  last_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               seen_ff;
   hhs_token_type      tok_ff;
   hhs_token_type      tok_in;

   logic [TIME_W-1:0] elapsed;
   logic              ok;
   logic [MASK_W-1:0] my_bit;

   always_comb begin
      elapsed = ctl.time_now - last_ff;
      ok      = seen_ff && (elapsed[TIME_W-1:LIMIT_W] == '0)
                && (elapsed[LIMIT_W-1:0] <= limit_ff);
      my_bit  = MASK_W'(1) << cell_id;
      tok_in.valid   = tok_up.valid;
      tok_in.healthy = tok_up.healthy | (ok ? my_bit : '0);
      tok_in.timeout = tok_up.timeout | ((!ok && ctl.to_en) ? my_bit : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         limit_ff <= limit_reset(cell_id);
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in;
         if (ctl.beat && (ctl.beat_ch == cell_id)) begin
            seen_ff <= 1'b1;
         end
         if (ctl.csr_we && (ctl.csr_idx == cell_id)) begin
            limit_ff <= ctl.csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.beat && (ctl.beat_ch == cell_id)) begin
         last_ff <= ctl.time_now;
      end
   end

   assign tok_out = tok_ff;
   assign seen    = seen_ff;

endmodule
`default_nettype wire

@@ verif/heartbeat_health_supervisor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat health supervisor checker
// Watches the request, result and register channels, keeps its own model of
// the supervisor and compares every result with the status it predicts.
// ----------------------------------------------------------------------------
module heartbeat_health_supervisor_checker import hhs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   hhs_req_if        req_mon,
   hhs_rsp_if        rsp_mon,
   hhs_csr_if        csr_mon,
   output int        fail_count,
   output int        pending
);

   localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT [CHANNELS] =
      '{16'd1500, 16'd1500, 16'd10000, 16'd5000, 16'd2000};

   // Modeled supervisor state.
   logic [TIME_W-1:0]  now_ticks;
   logic [TIME_W-1:0]  beat_at [CHANNELS];
   logic [MASK_W-1:0]  seen_bits;
   logic [MASK_W-1:0]  ok_bits;
   logic [MASK_W-1:0]  late_bits;
   logic               started;
   logic               armed;
   logic               faulted;
   logic [CH_W-1:0]    fault_ch;
   logic [LIMIT_W-1:0] limit_reg [CHANNELS];
   logic [LIMIT_W-1:0] grace_reg;

   hhs_rsp_type expected_status [$];
   int          errors = 0;
   int          waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   function automatic void clear_supervisor();
      int i;
      now_ticks = '0;
      for (i = 0; i < CHANNELS; i++) begin
         beat_at[i]   = '0;
         limit_reg[i] = LIMIT_DEFAULT[i];
      end
      seen_bits = '0;
      ok_bits   = '0;
      late_bits = '0;
      started   = 1'b0;
      armed     = 1'b0;
      faulted   = 1'b0;
      fault_ch  = '0;
      grace_reg = GRACE_RESET;
   endfunction

   // Applies one request to the model and returns the status it reports.
   function automatic hhs_rsp_type step_supervisor(input logic [ACT_W-1:0] act,
                                                   input logic [CH_W-1:0] ch);
      hhs_rsp_type       st;
      logic [MASK_W-1:0] good, late;
      logic [TIME_W-1:0] elapsed;
      logic              grace_over;
      logic              fed;
      int                i;
      fed  = 1'b0;
      good = '0;
      late = '0;
      case (act)
         ACT_TICK: now_ticks = now_ticks + 1'b1;
         ACT_BEAT: begin
            if (ch < CHANNELS) begin
               beat_at[ch]   = now_ticks;
               seen_bits[ch] = 1'b1;
            end
         end
         ACT_CHECK: begin
            // Once a fault has latched the supervisor is halted for good.
            if (!faulted) begin
               grace_over = now_ticks > TIME_W'(grace_reg);
               for (i = 0; i < CHANNELS; i++) begin
                  elapsed = now_ticks - beat_at[i];
                  if (seen_bits[i] && elapsed <= TIME_W'(limit_reg[i])) begin
                     good[i] = 1'b1;
                  end else if (started || grace_over) begin
                     late[i] = 1'b1;
                  end
               end
               ok_bits   = good;
               late_bits = late;
               if (good == ALL_MASK) begin
                  started = 1'b1;
                  armed   = 1'b1;
               end
               if (armed && late != '0) begin
                  faulted = 1'b1;
                  for (i = CHANNELS - 1; i >= 0; i--) begin
                     if (late[i]) begin
                        fault_ch = CH_W'(i);
                     end
                  end
               end else begin
                  fed = armed;
               end
            end
         end
         default: ;
      endcase
      st.seen_mask      = seen_bits;
      st.alive_mask     = ok_bits;
      st.expired_mask   = late_bits;
      st.startup_done   = started;
      st.watchdog_armed = armed;
      st.feed           = fed;
      st.fault          = faulted;
      st.fault_channel  = fault_ch;
      return st;
   endfunction

   always @(posedge clock) begin : watch_channels
      hhs_rsp_type got, want;
      if (reset) begin
         clear_supervisor();
         expected_status.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.seen_mask      = rsp_mon.seen_mask;
            got.alive_mask     = rsp_mon.alive_mask;
            got.expired_mask   = rsp_mon.expired_mask;
            got.startup_done   = rsp_mon.startup_done;
            got.watchdog_armed = rsp_mon.watchdog_armed;
            got.feed           = rsp_mon.feed;
            got.fault          = rsp_mon.fault;
            got.fault_channel  = rsp_mon.fault_channel;
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding, seen_mask %0h",
                                         got.seen_mask));
            end else begin
               want = expected_status.pop_front();
               compare_field("seen_mask", got.seen_mask, want.seen_mask);
               compare_field("alive_mask", got.alive_mask, want.alive_mask);
               compare_field("expired_mask", got.expired_mask, want.expired_mask);
               compare_field("startup_done", got.startup_done, want.startup_done);
               compare_field("watchdog_armed", got.watchdog_armed, want.watchdog_armed);
               compare_field("feed", got.feed, want.feed);
               compare_field("fault", got.fault, want.fault);
               compare_field("fault_channel", got.fault_channel, want.fault_channel);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_STARTUP_GRACE) begin
               grace_reg = csr_mon.data;
            end else if (csr_mon.index < REG_STARTUP_GRACE) begin
               limit_reg[csr_mon.index] = csr_mon.data;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_status.push_back(step_supervisor(req_mon.action, req_mon.channel));
         end
      end
      waiting <= expected_status.size();
   end

endmodule

@@ verif/heartbeat_health_supervisor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat health supervisor testbench
// Drives ticks, beats and checks into the supervisor in directed and random
// phases, reprograms the limits between phases and lets the checker compare
// every result with its own model of the block.
// ----------------------------------------------------------------------------
module heartbeat_health_supervisor_tb;
   import hhs_pkg::*;

   // The fourth action code does nothing; the two register indexes past the
   // startup grace are not mapped to anything.
   localparam logic [ACT_W-1:0]     ACT_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = REG_STARTUP_GRACE + 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = '1;

   // Points in the request count where the idling pattern changes.
   localparam int SWAP_AT  = 620;
   localparam int QUIET_AT = 1240;

   // Warmup traffic never beats the last channel, so the supervisor cannot arm.
   // Armed traffic keeps every channel fresh before each check, except the
   // channels that are deliberately starved. Free traffic is anything at all.
   typedef enum int {TRAFFIC_WARMUP, TRAFFIC_ARMED, TRAFFIC_FREE} traffic_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_take = 1'b0;

   int mismatches;
   int waiting_results;

   int idle_pct = 18;
   int stall_pct = 49;
   int requests_sent = 0;
   int programs_done = 0;
   int ticks_sent = 0;

   // What the stimulus side knows about each channel: whether it has beaten,
   // how many ticks have passed since, and the limit now programmed.
   logic               beat_given [CHANNELS];
   int                 since_beat [CHANNELS];
   logic [LIMIT_W-1:0] beat_limit [CHANNELS];

   hhs_req_if req_if ();
   hhs_rsp_if rsp_if ();
   hhs_csr_if csr_if ();

   assign rsp_if.ready = rsp_take;

   heartbeat_health_supervisor u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   heartbeat_health_supervisor_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .fail_count (mismatches),
      .pending    (waiting_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, at whatever rate the current phase sets.
   always @(posedge clock) begin
      rsp_take <= ($urandom_range(99) >= stall_pct);
   end

   // Sends one request and returns at the edge where it is accepted. Valid is
   // left high so back-to-back requests need no second assignment in one step;
   // it only drops when a gap is chosen or the sender waits for the results.
   task automatic send_request(input logic [ACT_W-1:0] act, input logic [CH_W-1:0] ch);
      int gap, i;
      if (requests_sent < SWAP_AT) begin
         idle_pct  = 18;
         stall_pct = 49;
      end else if (requests_sent < QUIET_AT) begin
         idle_pct  = 49;
         stall_pct = 18;
      end else begin
         idle_pct  = 0;
         stall_pct = 0;
      end
      gap = 0;
      while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.action  <= act;
      req_if.channel <= ch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
      if (act == ACT_TICK) begin
         ticks_sent++;
         for (i = 0; i < CHANNELS; i++) since_beat[i]++;
      end else if (act == ACT_BEAT && ch < CHANNELS) begin
         beat_given[ch] = 1'b1;
         since_beat[ch] = 0;
      end
   endtask

   // Holds the sender off until every outstanding result has been taken.
   // The count from the checker is updated at the clock edge, so drain waits for
   // a clock edge before each read of it, to be sure it covers the last accepted request.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (waiting_results != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [LIMIT_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // Writes all five limits from beat_limit, then the grace, then one of the
   // unmapped indexes, which the block must ignore.
   task automatic program_registers(input logic [LIMIT_W-1:0] grace);
      int i;
      for (i = 0; i < CHANNELS; i++) begin
         write_register(REG_LIMIT_INPUT + CSR_IDX_W'(i), beat_limit[i]);
      end
      write_register(REG_STARTUP_GRACE, grace);
      write_register(programs_done[0] ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                     LIMIT_W'($urandom));
      programs_done++;
      csr_if.valid <= 1'b0;
   endtask

   task automatic randomize_limits(input int hi);
      int i;
      for (i = 0; i < CHANNELS; i++) beat_limit[i] = LIMIT_W'($urandom_range(hi));
   endtask

   task automatic run_traffic(input int count, input traffic_kind_type kind,
                              input logic [MASK_W-1:0] starved);
      int k, pick, c;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // Noise: the unused action, or a beat from a channel that does
            // not exist.
            if ($urandom_range(1) == 1) begin
               send_request(ACT_UNUSED, CH_W'($urandom_range(7)));
            end else begin
               send_request(ACT_BEAT, CH_W'($urandom_range(7, CHANNELS)));
            end
         end else if (pick < 48) begin
            send_request(ACT_TICK, CH_W'($urandom_range(7)));
         end else if (pick < 78) begin
            case (kind)
               TRAFFIC_WARMUP: c = $urandom_range(CHANNELS - 2);
               TRAFFIC_ARMED:  c = $urandom_range(CHANNELS - 1);
               default:        c = $urandom_range(7);
            endcase
            if (kind == TRAFFIC_ARMED && starved[c]) begin
               send_request(ACT_TICK, CH_W'($urandom_range(7)));
            end else begin
               send_request(ACT_BEAT, CH_W'(c));
            end
         end else begin
            // Once armed, any stale channel at a check latches a fault and
            // halts the block, so every channel that is not starved beats
            // first if its age has gone past its limit. Ages thus reach the
            // limit exactly but never exceed it.
            if (kind == TRAFFIC_ARMED) begin
               for (c = 0; c < CHANNELS; c++) begin
                  if (!starved[c] && (!beat_given[c] || since_beat[c] > int'(beat_limit[c])))
                  begin
                     send_request(ACT_BEAT, CH_W'(c));
                  end
               end
            end
            send_request(ACT_CHECK, CH_W'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      int i, ph;
      req_if.valid   <= 1'b0;
      req_if.action  <= ACT_TICK;
      req_if.channel <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= REG_LIMIT_INPUT;
      csr_if.data    <= '0;
      for (i = 0; i < CHANNELS; i++) begin
         beat_given[i] = 1'b0;
         since_beat[i] = 0;
         beat_limit[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limits. A check at time zero finds
      // nothing seen and is still inside the grace period, so nothing times
      // out. The unused action and beats from channels past the last one
      // must leave the state alone.
      send_request(ACT_CHECK, '0);
      send_request(ACT_UNUSED, '1);
      for (i = CHANNELS; i < 8; i++) send_request(ACT_BEAT, CH_W'(i));
      send_request(ACT_BEAT, '0);
      send_request(ACT_CHECK, '0);
      send_request(ACT_TICK, '0);
      for (i = 1; i < CHANNELS - 1; i++) send_request(ACT_BEAT, CH_W'(i));
      send_request(ACT_CHECK, '0);

      // Zero grace and a mix of zero, small and largest limits. The last channel never beat, so the block
      // cannot arm and timeouts show up without a fault. A channel with a
      // zero limit is healthy only until the next tick after its beat.
      drain();
      beat_limit = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd0};
      program_registers('0);
      send_request(ACT_TICK, '0);
      send_request(ACT_CHECK, '0);
      send_request(ACT_BEAT, '0);
      send_request(ACT_CHECK, '0);
      send_request(ACT_TICK, '0);
      send_request(ACT_CHECK, '0);
      send_request(ACT_UNUSED, '0);

      // Warmup: small limits and a grace period that ends somewhere inside
      // the phase, so checks cross from the grace window into timeouts.
      for (ph = 0; ph < 3; ph++) begin
         drain();
         randomize_limits(40);
         program_registers(LIMIT_W'(ticks_sent + $urandom_range(60)));
         run_traffic(150, TRAFFIC_WARMUP, '0);
      end

      // The first armed check brings every channel up to date, so all are
      // healthy together, startup latches and the watchdog arms. Later checks
      // should all feed it. The limits move between moderate values, the
      // largest value and values near zero.
      for (ph = 0; ph < 3; ph++) begin
         drain();
         case (ph)
            0: begin
               randomize_limits(30);
               program_registers('1);
            end
            1: begin
               for (i = 0; i < CHANNELS; i++) beat_limit[i] = '1;
               program_registers(LIMIT_W'($urandom));
            end
            default: begin
               randomize_limits(3);
               program_registers('0);
            end
         endcase
         run_traffic(300, TRAFFIC_ARMED, '0);
      end

      // Starve a random set of channels until one goes stale at a check,
      // which latches the fault. After that checks change nothing, while
      // ticks and beats still move time and the seen mask.
      drain();
      randomize_limits(20);
      program_registers(LIMIT_W'($urandom));
      run_traffic(150, TRAFFIC_ARMED, MASK_W'($urandom_range(ALL_MASK, 1)));
      run_traffic(110, TRAFFIC_FREE, '0);

      drain();
      repeat (4 * CHANNELS) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog on the run itself: far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
src/hhs_pkg.sv
src/hhs_channels.sv
src/hhs_cell.sv
src/heartbeat_health_supervisor.sv
verif/heartbeat_health_supervisor_checker.sv
verif/heartbeat_health_supervisor_tb.sv
